>>> src/cpq_pkg.sv
// ----------------------------------------------------------------------------
// Coalescing packet queue: shared types and codes
// Item layouts, stored entry layout, check flags and the status, action,
// opcode and message type codes used across the queue.
// ----------------------------------------------------------------------------
package cpq_pkg;

	// Opcodes of an input item.
	localparam logic OP_ENQUEUE = 1'b0;
	localparam logic OP_POP     = 1'b1;

	// Message types.
	localparam logic [1:0] MT_HEARTBEAT = 2'd0;
	localparam logic [1:0] MT_STATE     = 2'd1;
	localparam logic [1:0] MT_INTENT    = 2'd2;
	localparam logic [1:0] MT_INVALID   = 2'd3;

	// Result status codes.
	localparam logic [2:0] ST_QUEUED    = 3'd0;
	localparam logic [2:0] ST_COALESCED = 3'd1;
	localparam logic [2:0] ST_FILTERED  = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_INVALID   = 3'd4;
	localparam logic [2:0] ST_EMPTY     = 3'd5;
	localparam logic [2:0] ST_POPPED    = 3'd6;

	// Dispatch classes of a popped packet.
	localparam logic [1:0] ACT_HEARTBEAT  = 2'd0;
	localparam logic [1:0] ACT_NO_HANDLER = 2'd1;
	localparam logic [1:0] ACT_INTENT     = 2'd2;
	localparam logic [1:0] ACT_STATE      = 2'd3;

	// One input item.
	typedef struct packed {
		logic        opcode;
		logic [1:0]  pkt_type;
		logic [7:0]  domain;
		logic [31:0] entity_id;
		logic [7:0]  intent;
		logic [7:0]  data_len;
		logic [63:0] payload_data;
		logic        state_accepted;
	} cmd_t;

	// One result item.
	typedef struct packed {
		logic [2:0]  status;
		logic [1:0]  action;
		logic [1:0]  out_pkt_type;
		logic [2:0]  out_domain;
		logic [31:0] out_entity_id;
		logic [7:0]  out_intent;
		logic [3:0]  out_data_len;
		logic [63:0] out_payload_data;
		logic [4:0]  occupancy;
	} result_t;

	// One queued packet as held in the entry memory.
	typedef struct packed {
		logic [1:0]  pkt_type;
		logic [7:0]  domain;
		logic [31:0] entity_id;
		logic [7:0]  intent;
		logic [3:0]  data_len;
		logic [63:0] payload_data;
	} entry_t;

	// Outcome of the front-end packet check.
	typedef struct packed {
		logic invalid;
		logic filtered;
	} check_t;

endpackage

>>> src/coalescing_packet_queue.sv
// ----------------------------------------------------------------------------
// Coalescing packet queue
// Ring buffer of control packets with checking, filtering and coalescing.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its single result
// appears for one cycle with done high and must be captured then. A pop of a
// nonempty queue and a heartbeat or intent enqueue keep busy high in the
// check and the pop or append state; an invalid or filtered packet and a pop
// of an empty queue, in the check state alone. A state enqueue walks the
// queue from newest to oldest with one compare per cycle on the entry memory
// read port, busy high throughout. The handler mask may be written through
// cfg_we and cfg_wdata whenever no item is in flight.
module coalescing_packet_queue
	import cpq_pkg::*;
#(
	parameter int ENTRY_COUNT   = 16,
	parameter int DOMAIN_SLOTS  = 8,
	parameter int PAYLOAD_BYTES = 8,
	parameter int INTENT_LIMIT  = 7
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  cmd_t       cmd,
	output logic       done,
	output result_t    result,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);

	localparam int IDX_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
	localparam int CNT_W = $clog2(ENTRY_COUNT + 1);
	localparam int SUM_W = $clog2(2 * ENTRY_COUNT);
	localparam logic [63:0] PAYLOAD_MASK = (PAYLOAD_BYTES >= 8) ? {64{1'b1}} :
		((64'd1 << (8 * PAYLOAD_BYTES)) - 64'd1);

	// Sequencer states.
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CHECK  = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_APPEND = 3'd3;
	localparam logic [2:0] S_POP    = 3'd4;

	logic [2:0]       state_q, state_d;
	logic [7:0]       handler_mask_q;
	cmd_t             req_q;
	logic [IDX_W-1:0] head_q, head_d;
	logic [CNT_W-1:0] fill_q, fill_d;
	logic [IDX_W-1:0] scan_idx_q, scan_idx_d;
	logic [CNT_W-1:0] scan_cnt_q, scan_cnt_d;
	logic             done_q, done_d;
	result_t          result_q, result_d;

	check_t           chk;
	logic             rd_en, wr_en;
	logic [IDX_W-1:0] rd_addr, wr_addr;
	entry_t           rd_data, new_entry;

	logic [SUM_W-1:0] tail_sum, newest_sum;
	logic [IDX_W-1:0] tail_idx, newest_idx, head_next, scan_prev;
	logic             key_match;
	logic [1:0]       pop_class;

	// Packet check on the held item.
	cpq_check #(
		.DOMAIN_SLOTS (DOMAIN_SLOTS),
		.PAYLOAD_BYTES(PAYLOAD_BYTES),
		.INTENT_LIMIT (INTENT_LIMIT)
	) u_check (
		.cmd         (req_q),
		.handler_mask(handler_mask_q),
		.chk         (chk)
	);

	// Entry memory.
	cpq_store #(
		.DEPTH(ENTRY_COUNT)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(new_entry),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Ring index arithmetic; every sum stays below twice the depth.
	always_comb begin
		tail_sum   = SUM_W'(head_q) + SUM_W'(fill_q);
		tail_idx   = (tail_sum >= SUM_W'(ENTRY_COUNT)) ?
			IDX_W'(tail_sum - SUM_W'(ENTRY_COUNT)) : IDX_W'(tail_sum);
		newest_sum = tail_sum - SUM_W'(1);
		newest_idx = (newest_sum >= SUM_W'(ENTRY_COUNT)) ?
			IDX_W'(newest_sum - SUM_W'(ENTRY_COUNT)) : IDX_W'(newest_sum);
		head_next  = (head_q == IDX_W'(ENTRY_COUNT - 1)) ? '0 : head_q + IDX_W'(1);
		scan_prev  = (scan_idx_q == '0) ? IDX_W'(ENTRY_COUNT - 1) : scan_idx_q - IDX_W'(1);
	end

	// Packet as it is stored, payload trimmed to the configured width.
	always_comb begin
		new_entry.pkt_type     = req_q.pkt_type;
		new_entry.domain       = req_q.domain;
		new_entry.entity_id    = req_q.entity_id;
		new_entry.intent       = req_q.intent;
		new_entry.data_len     = req_q.data_len[3:0];
		new_entry.payload_data = req_q.payload_data & PAYLOAD_MASK;
	end

	// Compare unit: the entry read last cycle against the held item.
	assign key_match = (rd_data.domain == req_q.domain) &&
		(rd_data.entity_id == req_q.entity_id);

	// Dispatch class of the entry at the head.
	always_comb begin
		if (rd_data.pkt_type == MT_HEARTBEAT) begin
			pop_class = ACT_HEARTBEAT;
		end else if (rd_data.domain[7:3] != 5'd0 || !handler_mask_q[rd_data.domain[2:0]]) begin
			pop_class = ACT_NO_HANDLER;
		end else if (rd_data.pkt_type == MT_INTENT) begin
			pop_class = ACT_INTENT;
		end else begin
			pop_class = ACT_STATE;
		end
	end

	// Sequencer.
	always_comb begin
		state_d    = state_q;
		head_d     = head_q;
		fill_d     = fill_q;
		scan_idx_d = scan_idx_q;
		scan_cnt_d = scan_cnt_q;
		rd_en      = 1'b0;
		rd_addr    = head_q;
		wr_en      = 1'b0;
		wr_addr    = tail_idx;
		done_d     = 1'b0;
		result_d   = '0;
		result_d.occupancy = 5'(fill_q);

		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_CHECK;
				end
			end

			S_CHECK: begin
				if (req_q.opcode == OP_POP) begin
					if (fill_q == '0) begin
						result_d.status = ST_EMPTY;
						result_d.occupancy = '0;
						done_d  = 1'b1;
						state_d = S_IDLE;
					end else begin
						rd_en   = 1'b1;
						rd_addr = head_q;
						state_d = S_POP;
					end
				end else if (chk.invalid) begin
					result_d.status = ST_INVALID;
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else if (chk.filtered) begin
					result_d.status = ST_FILTERED;
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else if (req_q.pkt_type == MT_STATE && fill_q != '0) begin
					rd_en      = 1'b1;
					rd_addr    = newest_idx;
					scan_idx_d = newest_idx;
					scan_cnt_d = fill_q;
					state_d    = S_SCAN;
				end else begin
					state_d = S_APPEND;
				end
			end

			S_SCAN: begin
				if (key_match) begin
					if (rd_data.pkt_type == MT_STATE) begin
						wr_en   = 1'b1;
						wr_addr = scan_idx_q;
						result_d.status = ST_COALESCED;
						done_d  = 1'b1;
						state_d = S_IDLE;
					end else begin
						state_d = S_APPEND;
					end
				end else if (scan_cnt_q == CNT_W'(1)) begin
					state_d = S_APPEND;
				end else begin
					rd_en      = 1'b1;
					rd_addr    = scan_prev;
					scan_idx_d = scan_prev;
					scan_cnt_d = scan_cnt_q - CNT_W'(1);
				end
			end

			S_APPEND: begin
				if (fill_q == CNT_W'(ENTRY_COUNT)) begin
					result_d.status = ST_FULL;
				end else begin
					wr_en   = 1'b1;
					wr_addr = tail_idx;
					fill_d  = fill_q + CNT_W'(1);
					result_d.status = ST_QUEUED;
					result_d.occupancy = 5'(fill_q + CNT_W'(1));
				end
				done_d  = 1'b1;
				state_d = S_IDLE;
			end

			S_POP: begin
				head_d = head_next;
				fill_d = fill_q - CNT_W'(1);
				result_d.status           = ST_POPPED;
				result_d.action           = pop_class;
				result_d.out_pkt_type     = rd_data.pkt_type;
				result_d.out_domain       = rd_data.domain[2:0];
				result_d.out_entity_id    = rd_data.entity_id;
				result_d.out_intent       = rd_data.intent;
				result_d.out_data_len     = rd_data.data_len;
				result_d.out_payload_data = rd_data.payload_data;
				result_d.occupancy        = 5'(fill_q - CNT_W'(1));
				done_d  = 1'b1;
				state_d = S_IDLE;
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			head_q         <= '0;
			fill_q         <= '0;
			done_q         <= 1'b0;
			handler_mask_q <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			fill_q  <= fill_d;
			done_q  <= done_d;
			if (cfg_we) begin
				handler_mask_q <= cfg_wdata;
			end
		end
	end

	// Held item, scan position and result payload.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			req_q <= cmd;
		end
		scan_idx_q <= scan_idx_d;
		scan_cnt_q <= scan_cnt_d;
		if (done_d) begin
			result_q <= result_d;
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTHESIS
	// The fill count never exceeds the queue depth.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(ENTRY_COUNT))
		else $error("fill count above queue depth");

	// A result only ends a busy period.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without an item in flight");

	// A pop removes exactly one packet.
	a_pop_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_POPPED) |-> (fill_q + CNT_W'(1) == $past(fill_q)))
		else $error("pop did not remove one packet");

	// Only an append grows the queue.
	a_append_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_QUEUED) |-> (fill_q == $past(fill_q) + CNT_W'(1)))
		else $error("append did not add one packet");

	// Results that store nothing new leave the fill count alone.
	a_keep_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status == ST_COALESCED || result.status == ST_FILTERED ||
		result.status == ST_FULL || result.status == ST_INVALID ||
		result.status == ST_EMPTY)) |-> (fill_q == $past(fill_q)))
		else $error("fill count changed without append or pop");

	// The reported occupancy is the live fill count.
	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.occupancy == 5'(fill_q)))
		else $error("occupancy does not match fill count");
`endif

endmodule

>>> src/cpq_store.sv
// ----------------------------------------------------------------------------
// Coalescing packet queue: entry memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cpq_store
	import cpq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  entry_t                   wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output entry_t                   rd_data
);

	entry_t mem_q [DEPTH];
	entry_t rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port, data registered.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> src/cpq_check.sv
// ----------------------------------------------------------------------------
// Coalescing packet queue: packet check
// Validates an enqueue item and decides whether a state packet is filtered.
// ----------------------------------------------------------------------------
module cpq_check
	import cpq_pkg::*;
#(
	parameter int DOMAIN_SLOTS  = 8,
	parameter int PAYLOAD_BYTES = 8,
	parameter int INTENT_LIMIT  = 7
) (
	input  cmd_t       cmd,
	input  logic [7:0] handler_mask,
	output check_t     chk
);

	logic ok;

	// Validity of type, length, domain and intent.
	always_comb begin
		if (cmd.pkt_type == MT_INVALID || cmd.data_len > 8'(PAYLOAD_BYTES)) begin
			ok = 1'b0;
		end else if (cmd.pkt_type == MT_HEARTBEAT) begin
			ok = (cmd.data_len == 8'd0);
		end else begin
			ok = (cmd.domain != 8'd0) && (cmd.domain < 8'(DOMAIN_SLOTS)) &&
				(cmd.intent <= 8'(INTENT_LIMIT));
		end
	end

	// A valid state packet has a domain below DOMAIN_SLOTS (eight by default), so the low bits index the mask.
	assign chk.invalid  = !ok;
	assign chk.filtered = ok && (cmd.pkt_type == MT_STATE) &&
		(!handler_mask[cmd.domain[2:0]] || !cmd.state_accepted);

endmodule

>>> bench/coalescing_packet_queue_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Coalescing packet queue testbench
// Runs a short table of hand-picked items, then phases of random traffic
// under several handler masks. Every result is checked field by field
// against a typed row's expectation, else a queue model in this bench.
// ----------------------------------------------------------------------------
module coalescing_packet_queue_tb;
	import cpq_pkg::*;

	localparam int QDEPTH       = 16;
	localparam int SLOTS        = 8;
	localparam int PBYTES       = 8;
	localparam int ILIMIT       = 7;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 20;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 50;

	// One row of the directed table: a mask write or an item.
	typedef struct {
		logic       is_cfg;
		logic [7:0] mask;
		cmd_t       item;
		logic       typed;
		result_t    want;
	} dir_row_t;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	cmd_t       cmd;
	logic       done;
	result_t    result;
	logic       cfg_we;
	logic [7:0] cfg_wdata;

	// Queue model state.
	entry_t      q_entry [QDEPTH];
	logic [3:0]  q_head;
	logic [4:0]  q_fill;
	logic [7:0]  q_mask;

	result_t     pending_results[$];
	dir_row_t    dir_rows[$];
	logic [31:0] hash_pool [4];
	int          err_count;
	int          stall_cycles;

	coalescing_packet_queue #(
		.ENTRY_COUNT(QDEPTH),
		.DOMAIN_SLOTS(SLOTS),
		.PAYLOAD_BYTES(PBYTES),
		.INTENT_LIMIT(ILIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	// Print one line per error and count it.
	task automatic report_error(string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		err_count++;
	endtask

	// Work out the result of one item and advance the queue model.
	function automatic result_t queue_outcome(cmd_t c);
		result_t    r;
		entry_t     e;
		logic [3:0] idx;
		logic       ok;
		int         k;
		r = '0;
		if (c.opcode == OP_POP) begin
			if (q_fill == 0) begin
				r.status = ST_EMPTY;
				return r;
			end
			e = q_entry[q_head];
			if (e.pkt_type == MT_HEARTBEAT)
				r.action = ACT_HEARTBEAT;
			else if (e.domain >= 8 || !q_mask[e.domain[2:0]])
				r.action = ACT_NO_HANDLER;
			else if (e.pkt_type == MT_INTENT)
				r.action = ACT_INTENT;
			else
				r.action = ACT_STATE;
			r.status = ST_POPPED;
			r.out_pkt_type = e.pkt_type;
			r.out_domain = e.domain[2:0];
			r.out_entity_id = e.entity_id;
			r.out_intent = e.intent;
			r.out_data_len = e.data_len;
			r.out_payload_data = e.payload_data;
			q_head = q_head + 4'd1;
			q_fill = q_fill - 5'd1;
			r.occupancy = q_fill;
			return r;
		end

		// Packet check.
		if (c.pkt_type == MT_INVALID || c.data_len > PBYTES)
			ok = 1'b0;
		else if (c.pkt_type == MT_HEARTBEAT)
			ok = (c.data_len == 0);
		else
			ok = c.domain > 0 && c.domain < SLOTS && c.intent <= ILIMIT;
		r.occupancy = q_fill;
		if (!ok) begin
			r.status = ST_INVALID;
			return r;
		end

		e.pkt_type = c.pkt_type;
		e.domain = c.domain;
		e.entity_id = c.entity_id;
		e.intent = c.intent;
		e.data_len = c.data_len[3:0];
		e.payload_data = c.payload_data;

		// State packets may be filtered or folded into a pending one.
		if (c.pkt_type == MT_STATE) begin
			if (!q_mask[c.domain[2:0]] || !c.state_accepted) begin
				r.status = ST_FILTERED;
				return r;
			end
			for (k = q_fill; k > 0; k--) begin
				idx = q_head + 4'(k - 1);
				if (q_entry[idx].domain == c.domain &&
						q_entry[idx].entity_id == c.entity_id) begin
					if (q_entry[idx].pkt_type == MT_STATE) begin
						q_entry[idx] = e;
						r.status = ST_COALESCED;
						return r;
					end
					break;
				end
			end
		end

		if (q_fill >= QDEPTH) begin
			r.status = ST_FULL;
		end else begin
			q_entry[q_head + q_fill[3:0]] = e;
			q_fill = q_fill + 5'd1;
			r.status = ST_QUEUED;
		end
		r.occupancy = q_fill;
		return r;
	endfunction

	function automatic cmd_t make_cmd(logic op, logic [1:0] mt, logic [7:0] dom,
			logic [31:0] hash, logic [7:0] intent, logic [7:0] len,
			logic [63:0] data, logic acc);
		cmd_t c;
		c.opcode = op;
		c.pkt_type = mt;
		c.domain = dom;
		c.entity_id = hash;
		c.intent = intent;
		c.data_len = len;
		c.payload_data = data;
		c.state_accepted = acc;
		return c;
	endfunction

	function automatic result_t make_res(logic [2:0] st, logic [4:0] occ);
		result_t r;
		r = '0;
		r.status = st;
		r.occupancy = occ;
		return r;
	endfunction

	function automatic void add_item(cmd_t c);
		dir_row_t row;
		row.is_cfg = 1'b0;
		row.mask = '0;
		row.item = c;
		row.typed = 1'b0;
		row.want = '0;
		dir_rows.push_back(row);
	endfunction

	function automatic void add_typed(cmd_t c, result_t w);
		dir_row_t row;
		row.is_cfg = 1'b0;
		row.mask = '0;
		row.item = c;
		row.typed = 1'b1;
		row.want = w;
		dir_rows.push_back(row);
	endfunction

	function automatic void add_cfg(logic [7:0] m);
		dir_row_t row;
		row.is_cfg = 1'b1;
		row.mask = m;
		row.item = '0;
		row.typed = 1'b0;
		row.want = '0;
		dir_rows.push_back(row);
	endfunction

	// Mostly well-formed packets over a few entities, with pops, noise and
	// packets broken in one field mixed in.
	function automatic cmd_t random_item(int enq_pct);
		cmd_t c;
		int   pick;
		int   kind;
		c.opcode = 1'($urandom_range(1));
		c.pkt_type = 2'($urandom_range(3));
		c.domain = 8'($urandom_range(255));
		c.entity_id = $urandom;
		c.intent = 8'($urandom_range(255));
		c.data_len = 8'($urandom_range(255));
		c.payload_data = {$urandom, $urandom};
		c.state_accepted = 1'($urandom_range(1));
		pick = $urandom_range(99);
		if (pick < 8)
			return c;
		if (pick < 8 + (92 * (100 - enq_pct)) / 100) begin
			c.opcode = OP_POP;
			return c;
		end
		c.opcode = OP_ENQUEUE;
		kind = $urandom_range(99);
		if (kind < 20)
			c.pkt_type = MT_HEARTBEAT;
		else if (kind < 75)
			c.pkt_type = MT_STATE;
		else
			c.pkt_type = MT_INTENT;
		if (c.pkt_type == MT_HEARTBEAT) begin
			if ($urandom_range(3) != 0)
				c.domain = 8'($urandom_range(SLOTS - 1));
			c.data_len = 8'd0;
		end else begin
			c.domain = 8'($urandom_range(SLOTS - 1, 1));
			c.data_len = 8'($urandom_range(PBYTES));
		end
		if ($urandom_range(7) != 0)
			c.entity_id = hash_pool[$urandom_range(3)];
		c.intent = 8'($urandom_range(ILIMIT));
		c.state_accepted = ($urandom_range(9) != 0);

		// Break one field now and then.
		if ($urandom_range(99) < 6) begin
			case ($urandom_range(3))
				0: c.pkt_type = MT_INVALID;
				1: c.data_len = 8'($urandom_range(255, PBYTES + 1));
				2: c.domain = ($urandom_range(1) != 0) ? 8'd0 : 8'($urandom_range(255, SLOTS));
				default: c.intent = 8'($urandom_range(255, ILIMIT + 1));
			endcase
		end
		return c;
	endfunction

	// Mostly short gaps, a few long ones.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// Present one item and hold it until it is taken.
	task automatic send_item(cmd_t c, logic typed, result_t want);
		result_t predicted;
		@(negedge clk);
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predicted = queue_outcome(c);
		pending_results.push_back(typed ? want : predicted);
	endtask

	task automatic hold_off(int n);
		if (n > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (n - 1)
				@(negedge clk);
		end
	endtask

	// Write the handler mask once the queue has gone quiet.
	task automatic write_mask(logic [7:0] m);
		@(negedge clk);
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0 || busy)
			@(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		q_mask = m;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Check each result against the oldest expectation.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_error($sformatf("result with nothing expected, status %0d",
					result.status));
			end else begin
				want = pending_results.pop_front();
				if (result.status !== want.status)
					report_error($sformatf("status %0d, expected %0d",
						result.status, want.status));
				if (result.action !== want.action)
					report_error($sformatf("action %0d, expected %0d",
						result.action, want.action));
				if (result.out_pkt_type !== want.out_pkt_type)
					report_error($sformatf("out_pkt_type %0d, expected %0d",
						result.out_pkt_type, want.out_pkt_type));
				if (result.out_domain !== want.out_domain)
					report_error($sformatf("out_domain %0d, expected %0d",
						result.out_domain, want.out_domain));
				if (result.out_entity_id !== want.out_entity_id)
					report_error($sformatf("out_entity_id %h, expected %h",
						result.out_entity_id, want.out_entity_id));
				if (result.out_intent !== want.out_intent)
					report_error($sformatf("out_intent %0d, expected %0d",
						result.out_intent, want.out_intent));
				if (result.out_data_len !== want.out_data_len)
					report_error($sformatf("out_data_len %0d, expected %0d",
						result.out_data_len, want.out_data_len));
				if (result.out_payload_data !== want.out_payload_data)
					report_error($sformatf("out_payload_data %h, expected %h",
						result.out_payload_data, want.out_payload_data));
				if (result.occupancy !== want.occupancy)
					report_error($sformatf("occupancy %0d, expected %0d",
						result.occupancy, want.occupancy));
			end
		end
	end

	// End the run if nothing moves for too long.
	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("coalescing_packet_queue_tb: done, errors");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		logic [7:0] phase_mask [PHASES];
		int         enq_pct [PHASES];
		dir_row_t   row;
		int         ph;
		int         i;

		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		err_count = 0;
		q_head = '0;
		q_fill = '0;
		q_mask = '0;
		for (i = 0; i < QDEPTH; i++)
			q_entry[i] = '0;

		repeat (6)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed items: checks, filtering, coalescing and pop classes.
		add_typed(make_cmd(OP_POP, MT_HEARTBEAT, 0, 0, 0, 0, 0, 0),
			make_res(ST_EMPTY, 0));
		add_typed(make_cmd(OP_ENQUEUE, MT_INVALID, 1, 32'h1, 0, 0, 0, 1),
			make_res(ST_INVALID, 0));
		add_typed(make_cmd(OP_ENQUEUE, MT_HEARTBEAT, 0, 32'h2, 0, 1, 64'h5, 1),
			make_res(ST_INVALID, 0));
		add_typed(make_cmd(OP_ENQUEUE, MT_STATE, 0, 32'h3, 0, 0, 0, 1),
			make_res(ST_INVALID, 0));
		add_typed(make_cmd(OP_ENQUEUE, MT_INTENT, 8, 32'h4, 0, 0, 0, 1),
			make_res(ST_INVALID, 0));
		add_typed(make_cmd(OP_ENQUEUE, MT_INTENT, 255, 32'h4, 0, 0, 0, 1),
			make_res(ST_INVALID, 0));
		add_typed(make_cmd(OP_ENQUEUE, MT_INTENT, 3, 32'h5, 8, 0, 0, 1),
			make_res(ST_INVALID, 0));
		add_typed(make_cmd(OP_ENQUEUE, MT_STATE, 2, 32'h6, 0, 9, 0, 1),
			make_res(ST_INVALID, 0));
		add_typed(make_cmd(OP_ENQUEUE, MT_STATE, 2, 32'h6, 0, 2, 64'h1234, 1),
			make_res(ST_FILTERED, 0));
		add_typed(make_cmd(OP_ENQUEUE, MT_HEARTBEAT, 255, 32'hFFFF_FFFF, 255, 0,
			'1, 1), make_res(ST_QUEUED, 1));
		add_cfg(8'hFF);
		add_typed(make_cmd(OP_ENQUEUE, MT_INTENT, 7, 32'h0, 7, 8, '1, 0),
			make_res(ST_QUEUED, 2));
		add_typed(make_cmd(OP_ENQUEUE, MT_STATE, 1, 32'hA5A5_0001, 1, 4,
			64'h0102_0304, 0), make_res(ST_FILTERED, 2));
		add_typed(make_cmd(OP_ENQUEUE, MT_STATE, 1, 32'hA5A5_0001, 1, 4,
			64'h0102_0304, 1), make_res(ST_QUEUED, 3));
		add_typed(make_cmd(OP_ENQUEUE, MT_STATE, 1, 32'hA5A5_0001, 3, 8,
			64'hDEAD_BEEF_CAFE_F00D, 1), make_res(ST_COALESCED, 3));
		add_item(make_cmd(OP_ENQUEUE, MT_INTENT, 2, 32'h0000_00B2, 5, 1, 64'h77, 1));
		add_typed(make_cmd(OP_ENQUEUE, MT_STATE, 2, 32'h0000_00B2, 0, 0, 0, 1),
			make_res(ST_QUEUED, 5));
		add_typed(make_cmd(OP_ENQUEUE, MT_STATE, 2, 32'h0000_00B2, 6, 3, 64'h99, 1),
			make_res(ST_COALESCED, 5));
		add_item(make_cmd(OP_ENQUEUE, MT_HEARTBEAT, 3, 32'h0000_0C03, 0, 0, 0, 1));
		add_typed(make_cmd(OP_ENQUEUE, MT_STATE, 3, 32'h0000_0C03, 2, 2, 64'h55, 1),
			make_res(ST_QUEUED, 7));
		add_cfg(8'h00);
		add_item(make_cmd(OP_POP, MT_INVALID, 255, '1, 255, 255, '1, 1));
		add_item(make_cmd(OP_POP, MT_HEARTBEAT, 0, 0, 0, 0, 0, 0));
		add_cfg(8'hAA);
		add_item(make_cmd(OP_POP, MT_HEARTBEAT, 0, 0, 0, 0, 0, 0));
		add_item(make_cmd(OP_POP, MT_HEARTBEAT, 0, 0, 0, 0, 0, 0));
		add_item(make_cmd(OP_POP, MT_HEARTBEAT, 0, 0, 0, 0, 0, 0));
		add_item(make_cmd(OP_POP, MT_HEARTBEAT, 0, 0, 0, 0, 0, 0));

		foreach (dir_rows[r]) begin
			row = dir_rows[r];
			if (row.is_cfg) begin
				write_mask(row.mask);
			end else begin
				send_item(row.item, row.typed, row.want);
				hold_off(pick_gap());
			end
		end

		// Random phases, each under its own mask and enqueue share.
		phase_mask[0] = 8'hFF;
		phase_mask[1] = 8'h00;
		phase_mask[2] = 8'($urandom);
		phase_mask[3] = 8'hFE;
		phase_mask[4] = 8'h01;
		phase_mask[5] = 8'($urandom);
		phase_mask[6] = 8'hFF;
		phase_mask[7] = 8'($urandom);
		enq_pct[0] = 95;
		enq_pct[1] = 70;
		enq_pct[2] = 50;
		enq_pct[3] = 90;
		enq_pct[4] = 30;
		enq_pct[5] = 85;
		enq_pct[6] = 60;
		enq_pct[7] = 40;
		for (ph = 0; ph < PHASES; ph++) begin
			write_mask(phase_mask[ph]);
			for (i = 0; i < 4; i++)
				hash_pool[i] = $urandom;
			for (i = 0; i < PHASE_ITEMS; i++) begin
				send_item(random_item(enq_pct[ph]), 1'b0, '0);
				// Two phases run back to back with no idle cycles.
				if (ph != 3 && ph != 6)
					hold_off(pick_gap());
			end
		end

		// Drain and let any stray result show up.
		@(negedge clk);
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (err_count == 0)
			$display("coalescing_packet_queue_tb: done, clean");
		else
			$display("coalescing_packet_queue_tb: done, errors");
		$finish;
	end

endmodule

>>> filelist.f
src/cpq_pkg.sv
src/cpq_store.sv
src/cpq_check.sv
src/coalescing_packet_queue.sv
bench/coalescing_packet_queue_tb.sv
